FILE: design/event_flag_group_waiter_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the event flag group waiter engine
// Clocked concurrent checks, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef EVENT_FLAG_GROUP_WAITER_ENGINE_UNIT_MACROS_SVH
`define EVENT_FLAG_GROUP_WAITER_ENGINE_UNIT_MACROS_SVH

// Check that is ignored while reset is asserted.
`define EFG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that must also hold during reset.
`define EFG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/efg_pkg.sv
// ----------------------------------------------------------------------------
// efg_pkg
// Shared types and codes of the event flag group waiter engine.
// ----------------------------------------------------------------------------
`default_nettype none

package efg_pkg;

    localparam int WAITERS_DEF   = 16;
    localparam int FLAG_BITS_DEF = 32;
    localparam int IDX_W         = 6;   // slot index carried between modules

    // function codes
    localparam logic [1:0] FUNC_WAIT   = 2'd0;
    localparam logic [1:0] FUNC_SET    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_CANCEL = 2'd3;

    // result status codes
    localparam logic [2:0] ST_SAT    = 3'd0;
    localparam logic [2:0] ST_QUEUED = 3'd1;
    localparam logic [2:0] ST_UNSAT  = 3'd2;
    localparam logic [2:0] ST_CANCEL = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] mask;
        logic [3:0]  waiter_id;
        logic        match_all;
        logic        consume;
        logic        block_if_unsatisfied;
    } efg_in_t;

    typedef struct packed {
        logic [3:0]  result_waiter;
        logic [2:0]  status;
        logic [31:0] snapshot;
        logic [31:0] flags_now;
        logic        last;
    } efg_out_t;

    // controller -> datapath
    typedef struct packed {
        logic             cap;        // capture input beat
        logic             single;     // execute a one-result item
        logic             set_start;  // OR flags in, clear scan state
        logic             eval;       // test slot read last cycle
        logic             fold;       // clear union of consumed masks
        logic             emit_rel;   // emit release for slot_idx
        logic             emit_done;  // emit closing beat of a set
        logic [IDX_W-1:0] slot_idx;   // read / walk index
        logic [IDX_W-1:0] eval_idx;   // index of the slot under test
    } efg_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic set_go;    // captured item is a set with nonzero mask
        logic out_free;  // output register can take a beat
        logic rel_hit;   // slot at slot_idx is to be released
    } efg_stat_t;

endpackage

`default_nettype wire

FILE: design/event_flag_group_waiter_engine_unit.sv
// A wait, clear, cancel or rejected item passes from the item register to the output register.
// Item flow: one item at a time; a set item's run is set by the one-slot-a-cycle scan
// of the slot table port and the walk over the release vector.
// Output stalls add cycles only where a beat waits for the output register.
// Reset (synchronous, aresetn low): flag word zero, all slots idle, no clearing pass.
// ----------------------------------------------------------------------------
// event_flag_group_waiter_engine_unit
// Event flag group with waiter slots: wait, set, clear and cancel items.
// ----------------------------------------------------------------------------
`default_nettype none

module event_flag_group_waiter_engine_unit #(
    parameter int WAITERS   = efg_pkg::WAITERS_DEF,
    parameter int FLAG_BITS = efg_pkg::FLAG_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // input beats
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire efg_pkg::efg_in_t s_item,
    // result beats
    output logic                  m_valid,
    input  wire logic             m_ready,
    output efg_pkg::efg_out_t     m_result
);
    import efg_pkg::*;

    // The controller steps through one item at a time:
    //   idle   - take an input beat into the item register
    //   decode - one-result items finish here as soon as the output register
    //            is free; a set item ORs its mask in and starts the scan
    //   scan   - one slot read per cycle, tested against the new flag word in
    //            the cycle after; hits build the release vector and the union of
    //            consumed masks
    //   fold   - consumed flags are cleared from the word
    //   walk   - release beats in ascending slot order, each carrying the
    //            pre-fold snapshot and the post-fold word
    //   finish - closing done beat of the set item
    // The input side is free again in idle even if a result beat still waits.

    efg_cmd_t  cmd;
    efg_stat_t stat;

    efg_ctrl #(
        .WAITERS (WAITERS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    efg_dp #(
        .WAITERS   (WAITERS),
        .FLAG_BITS (FLAG_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

FILE: design/efg_ctrl.sv
// ----------------------------------------------------------------------------
// efg_ctrl
// Sequencer: item capture, slot scan, mask fold and release walk.
// ----------------------------------------------------------------------------
`default_nettype none

module efg_ctrl #(
    parameter int WAITERS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire efg_pkg::efg_stat_t stat,
    output efg_pkg::efg_cmd_t      cmd
);
    import efg_pkg::*;

    localparam int CW = $clog2(WAITERS + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_FOLD   = 6'b001000,
        S_WALK   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.slot_idx = IDX_W'(cnt_reg);
        cmd.eval_idx = IDX_W'(cnt_reg - CW'(1));
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap    = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.set_go) begin
                    cmd.set_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_SCAN;
                end else if (stat.out_free) begin
                    cmd.single = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                // read at cnt, test the slot read in the previous cycle
                cmd.eval = (cnt_reg != '0);
                if (cnt_reg == CW'(WAITERS)) begin
                    state_next = S_FOLD;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_FOLD: begin
                cmd.fold   = 1'b1;
                cnt_next   = '0;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (!stat.rel_hit || stat.out_free) begin
                    cmd.emit_rel = stat.rel_hit;
                    if (cnt_reg == CW'(WAITERS - 1)) begin
                        state_next = S_FINISH;
                    end else begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/efg_dp.sv
// ----------------------------------------------------------------------------
// efg_dp
// Flag word, slot table, release vector and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_flag_group_waiter_engine_unit_macros.svh"

module efg_dp #(
    parameter int WAITERS   = 16,
    parameter int FLAG_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire efg_pkg::efg_in_t  s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output efg_pkg::efg_out_t      m_result,
    input  wire efg_pkg::efg_cmd_t cmd,
    output efg_pkg::efg_stat_t     stat
);
    import efg_pkg::*;

    localparam int W   = FLAG_BITS;
    localparam int IDW = (WAITERS > 1) ? $clog2(WAITERS) : 1;

    function automatic logic [31:0] to32(input logic [W-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[31:0];
    endfunction

    function automatic logic cond_met(input logic [W-1:0] req, input logic all,
                                      input logic [W-1:0] word);
        logic [W-1:0] hit;
        hit = req & word;
        return all ? (hit == req) : (hit != '0);
    endfunction

    efg_in_t        item_reg;
    logic [W-1:0]   flag_reg, flag_next;
    logic [W-1:0]   snap_reg, snap_next;
    logic [W-1:0]   clr_reg, clr_next;
    logic [WAITERS-1:0] busy_reg, busy_next;
    logic [WAITERS-1:0] rel_reg, rel_next;
    logic           out_vld_reg, out_vld_next;
    efg_out_t       out_reg, out_next;
    efg_out_t       res;
    logic           load;
    logic           wr_en;

    logic [W+1:0]   slot_mem [WAITERS];
    logic [W+1:0]   rd_reg;

    // decoded item
    logic [63:0]    mask_wide;
    logic [W-1:0]   m;
    logic [IDX_W-1:0] id6;
    logic [IDW-1:0] qidx, sidx, eidx;
    logic [63:0]    busy_wide;
    logic           id_oor, busy_id;
    logic [W-1:0]   rd_mask;
    logic           rd_all, rd_cons, slot_hit;

    assign mask_wide = 64'(item_reg.mask);
    assign m         = mask_wide[W-1:0];
    assign id6       = IDX_W'(item_reg.waiter_id);
    assign qidx      = id6[IDW-1:0];
    assign sidx      = cmd.slot_idx[IDW-1:0];
    assign eidx      = cmd.eval_idx[IDW-1:0];
    assign busy_wide = 64'(busy_reg);
    assign id_oor    = 32'(item_reg.waiter_id) >= 32'(WAITERS);
    assign busy_id   = busy_wide[id6];
    assign rd_mask   = rd_reg[W-1:0];
    assign rd_all    = rd_reg[W];
    assign rd_cons   = rd_reg[W+1];
    assign slot_hit  = busy_reg[eidx] && cond_met(rd_mask, rd_all, flag_reg);

    assign stat.set_go   = (item_reg.func == FUNC_SET) && (m != '0);
    assign stat.out_free = !out_vld_reg || m_ready;
    assign stat.rel_hit  = rel_reg[sidx];

    always_comb begin
        flag_next = flag_reg;
        snap_next = snap_reg;
        clr_next  = clr_reg;
        busy_next = busy_reg;
        rel_next  = rel_reg;
        wr_en     = 1'b0;
        load      = 1'b0;
        res       = '0;

        if (cmd.set_start) begin
            flag_next = flag_reg | m;
            snap_next = flag_reg | m;
            clr_next  = '0;
            rel_next  = '0;
        end

        if (cmd.eval && slot_hit) begin
            rel_next[eidx] = 1'b1;
            if (rd_cons) begin
                clr_next = clr_reg | rd_mask;
            end
        end

        if (cmd.fold) begin
            flag_next = flag_reg & ~clr_reg;
        end

        if (cmd.emit_rel) begin
            busy_next[sidx]   = 1'b0;
            load              = 1'b1;
            res.result_waiter = cmd.slot_idx[3:0];
            res.status        = ST_SAT;
            res.snapshot      = to32(snap_reg);
            res.flags_now     = to32(flag_reg);
            res.last          = 1'b0;
        end

        if (cmd.emit_done) begin
            load          = 1'b1;
            res.status    = ST_DONE;
            res.flags_now = to32(flag_reg);
            res.last      = 1'b1;
        end

        if (cmd.single) begin
            load          = 1'b1;
            res.last      = 1'b1;
            res.flags_now = to32(flag_reg);
            case (item_reg.func)
                FUNC_WAIT: begin
                    res.result_waiter = item_reg.waiter_id;
                    if (m == '0 || id_oor || busy_id) begin
                        res.status = ST_REJECT;
                    end else if (cond_met(m, item_reg.match_all, flag_reg)) begin
                        res.status   = ST_SAT;
                        res.snapshot = to32(flag_reg);
                        if (item_reg.consume) begin
                            flag_next     = flag_reg & ~m;
                            res.flags_now = to32(flag_reg & ~m);
                        end
                    end else if (item_reg.block_if_unsatisfied) begin
                        wr_en           = 1'b1;
                        busy_next[qidx] = 1'b1;
                        res.status      = ST_QUEUED;
                    end else begin
                        res.status = ST_UNSAT;
                    end
                end
                FUNC_SET: begin
                    // only a zero mask gets here
                    res.status = ST_REJECT;
                end
                FUNC_CLEAR: begin
                    if (m == '0) begin
                        res.status = ST_REJECT;
                    end else begin
                        flag_next     = flag_reg & ~m;
                        res.flags_now = to32(flag_reg & ~m);
                        res.status    = ST_DONE;
                    end
                end
                FUNC_CANCEL: begin
                    res.result_waiter = item_reg.waiter_id;
                    if (id_oor || !busy_id) begin
                        res.status = ST_REJECT;
                    end else begin
                        busy_next[qidx] = 1'b0;
                        res.status      = ST_CANCEL;
                    end
                end
                default: begin
                    res.status = ST_REJECT;
                end
            endcase
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg && !m_ready;
        out_next     = out_reg;
        if (load) begin
            out_vld_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg    <= '0;
            busy_reg    <= '0;
            rel_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            flag_reg    <= flag_next;
            busy_reg    <= busy_next;
            rel_reg     <= rel_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
        clr_reg  <= clr_next;
        out_reg  <= out_next;
        if (cmd.cap) begin
            item_reg <= s_item;
        end
    end

    // slot table: written by a queued wait, read once per scan step
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[qidx] <= {item_reg.consume, item_reg.match_all, m};
        end
        rd_reg <= slot_mem[sidx];
    end

    assign m_valid  = out_vld_reg;
    assign m_result = out_reg;

    `EFG_ASSERT(a_no_overwrite, aclk, aresetn, (load && out_vld_reg) |-> m_ready, "output beat overwritten")
    `EFG_ASSERT(a_rel_busy, aclk, aresetn, cmd.emit_rel |-> busy_reg[sidx], "release of idle slot")
    `EFG_ASSERT(a_fold_clears, aclk, aresetn, cmd.fold |=> ((flag_reg & clr_reg) == '0), "consumed flags left set")
    `EFG_ASSERT(a_one_load, aclk, aresetn, $countones({cmd.single, cmd.emit_rel, cmd.emit_done}) <= 1, "two result sources at once")

endmodule

`default_nettype wire
